>>> sv/ahfr_pkg.sv
package ahfr_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int AMP_W = 18;
  localparam logic [AMP_W-1:0] THRESH_RESET = AMP_W'(4);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [COUNT_W-1:0] BODY_START = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] LEN_LONG = COUNT_W'(53);
  localparam logic [COUNT_W-1:0] LEN_SHORT = COUNT_W'(21);
  localparam logic [COUNT_W-1:0] FCS_BYTES = COUNT_W'(2);
  localparam logic [5:0] ID_LONG = 6'd5;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic crc_ok;
    logic [5:0] message_kind;
    logic short_frame;
  } result_t;

  // Handoff from the bit layer to the byte layer
  typedef struct packed {
    logic byte_done;
    logic [7:0] byte_value;
  } unpack_t;

  // CRC-16/X.25, reflected, one byte per call
  function automatic logic [15:0] crc16_x25_byte(logic [15:0] crc, logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage

>>> sv/ahfr_if.sv
interface ahfr_symbol_if;
  logic valid;
  logic ready;
  logic start_req;
  logic [ahfr_pkg::AMP_W-1:0] amplitude;
  logic fm_positive;

  modport source (output valid, start_req, amplitude, fm_positive, input ready);
  modport sink (input valid, start_req, amplitude, fm_positive, output ready);
endinterface

interface ahfr_result_if;
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  logic crc_ok;
  logic [5:0] message_kind;
  logic short_frame;

  modport source (output valid, kind, byte_value, byte_index, crc_ok, message_kind,
                  short_frame, input ready);
  modport sink (input valid, kind, byte_value, byte_index, crc_ok, message_kind,
                short_frame, output ready);
endinterface

interface ahfr_cfg_if;
  logic valid;
  logic ready;
  logic [ahfr_pkg::AMP_W-1:0] weak_threshold;

  modport source (output valid, weak_threshold, input ready);
  modport sink (input valid, weak_threshold, output ready);
endinterface

>>> sv/ahfr_bit_unpack.sv
module ahfr_bit_unpack (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic step,
  input  logic level,
  output ahfr_pkg::unpack_t unpack
);
  import ahfr_pkg::*;

  logic prev_level_valid, prev_level_valid_next;
  logic prev_level, prev_level_next;
  logic [2:0] ones_run, ones_run_next;
  logic [2:0] bit_position, bit_position_next;
  logic [7:0] byte_shift, byte_shift_next;

  logic eff_pvv, eff_pl;
  logic [2:0] eff_ones, eff_pos;
  logic [7:0] eff_shift, merged;
  logic bit_val;

  always_comb begin
    // a start symbol opens from a clean slate in the same cycle
    eff_pvv   = clear ? 1'b0 : prev_level_valid;
    eff_pl    = clear ? 1'b0 : prev_level;
    eff_ones  = clear ? 3'd0 : ones_run;
    eff_pos   = clear ? 3'd0 : bit_position;
    eff_shift = clear ? 8'd0 : byte_shift;

    prev_level_valid_next = eff_pvv;
    prev_level_next       = eff_pl;
    ones_run_next         = eff_ones;
    bit_position_next     = eff_pos;
    byte_shift_next       = eff_shift;
    unpack.byte_done      = 1'b0;

    bit_val = eff_pvv && (level == eff_pl);
    merged = eff_shift | (bit_val ? (8'd1 << eff_pos) : 8'd0);
    unpack.byte_value = merged;

    if (step) begin
      prev_level_next = level;
      prev_level_valid_next = 1'b1;
      if (eff_ones >= 3'd5 && !bit_val) begin
        // stuffed zero, dropped
        ones_run_next = 3'd0;
      end else begin
        if (eff_ones >= 3'd5) begin
          ones_run_next = 3'd1;
        end else begin
          ones_run_next = bit_val ? eff_ones + 3'd1 : 3'd0;
        end
        if (eff_pos != 3'd7) begin
          bit_position_next = eff_pos + 3'd1;
          byte_shift_next = merged;
        end else begin
          bit_position_next = 3'd0;
          byte_shift_next = 8'd0;
          unpack.byte_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level_valid <= 1'b0;
      prev_level <= 1'b0;
      ones_run <= 3'd0;
      bit_position <= 3'd0;
      byte_shift <= 8'd0;
    end else begin
      prev_level_valid <= prev_level_valid_next;
      prev_level <= prev_level_next;
      ones_run <= ones_run_next;
      bit_position <= bit_position_next;
      byte_shift <= byte_shift_next;
    end
  end

  a_ones_bounded: assert property (@(posedge clk) disable iff (rst)
    ones_run <= 3'd5)
    else $error("ones run exceeded five");

  a_done_only_on_step: assert property (@(posedge clk) disable iff (rst)
    unpack.byte_done |-> step && bit_position_next == 3'd0)
    else $error("byte completed without a step");

  a_clear_restarts: assert property (@(posedge clk) disable iff (rst)
    clear && !step |=> !prev_level_valid && bit_position == 3'd0)
    else $error("clear left bit state behind");

endmodule

>>> sv/ais_hdlc_frame_receiver_unit.sv
// Latency: a result is valid the cycle after the symbol transfer that causes it.
// Throughput: one symbol per cycle; a symbol is taken while the result register
// is empty or being drained, so a stalled result holds the input for that time.
// Each symbol passes once through NRZI/destuff/packing and the byte CRC update.
// Reset (rst, synchronous, active high): no frame active, result register empty,
// weak_threshold back to 4.
module ais_hdlc_frame_receiver_unit (
  input logic clk,
  input logic rst,
  ahfr_symbol_if.sink symbol,
  ahfr_result_if.source result,
  ahfr_cfg_if.sink cfg
);
  import ahfr_pkg::*;

  logic [AMP_W-1:0] weak_threshold;
  logic frame_active, frame_active_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0] crc_reg, crc_reg_next;
  logic [5:0] message_id_reg, message_id_reg_next;
  logic [7:0] fcs_low, fcs_low_next;
  logic [7:0] fcs_high, fcs_high_next;

  logic res_valid;
  result_t res, res_next;
  logic res_load;

  logic xfer, start, below_thresh, eff_active, step, verdict;
  logic [COUNT_W-1:0] eff_count, len_v, len_b;
  logic [15:0] eff_crc;
  logic [5:0] eff_id, id_new;
  logic [7:0] eff_fcs_low, eff_fcs_high;
  unpack_t unpack;

  assign cfg.ready = 1'b1;
  assign symbol.ready = !res_valid || result.ready;
  assign xfer = symbol.valid && symbol.ready;
  assign start = symbol.start_req;

  ahfr_bit_unpack u_unpack (
    .clk    (clk),
    .rst    (rst),
    .clear  (xfer && start),
    .step   (step),
    .level  (!symbol.fm_positive),
    .unpack (unpack)
  );

  always_comb begin
    eff_count    = start ? '0 : byte_count;
    eff_crc      = start ? CRC_INIT : crc_reg;
    eff_id       = start ? 6'd0 : message_id_reg;
    eff_fcs_low  = start ? 8'd0 : fcs_low;
    eff_fcs_high = start ? 8'd0 : fcs_high;

    below_thresh = symbol.amplitude < weak_threshold;
    eff_active = frame_active || start;
    step = xfer && eff_active && !below_thresh;
    verdict = xfer && eff_active && below_thresh;

    len_v = (eff_id == ID_LONG) ? LEN_LONG : LEN_SHORT;
    id_new = (eff_count == BODY_START) ? unpack.byte_value[7:2] : eff_id;
    len_b = (id_new == ID_LONG) ? LEN_LONG : LEN_SHORT;

    frame_active_next   = frame_active;
    byte_count_next     = byte_count;
    crc_reg_next        = crc_reg;
    message_id_reg_next = message_id_reg;
    fcs_low_next        = fcs_low;
    fcs_high_next       = fcs_high;
    res_load            = 1'b0;

    res_next.kind         = KIND_BYTE;
    res_next.byte_value   = unpack.byte_value;
    res_next.byte_index   = eff_count[7:0];
    res_next.crc_ok       = 1'b0;
    res_next.message_kind = id_new;
    res_next.short_frame  = 1'b0;

    if (xfer) begin
      frame_active_next   = eff_active;
      byte_count_next     = eff_count;
      crc_reg_next        = eff_crc;
      message_id_reg_next = eff_id;
      fcs_low_next        = eff_fcs_low;
      fcs_high_next       = eff_fcs_high;
    end

    if (verdict) begin
      frame_active_next = 1'b0;
      res_load = 1'b1;
      res_next.kind = KIND_VERDICT;
      res_next.byte_value = 8'd0;
      res_next.message_kind = eff_id;
      res_next.short_frame = eff_count < BODY_START + len_v + FCS_BYTES;
      res_next.crc_ok = !res_next.short_frame && (~eff_crc == {eff_fcs_high, eff_fcs_low});
    end else if (step && unpack.byte_done && eff_count < COUNT_W'(MAX_FRAME_BYTES)) begin
      res_load = 1'b1;
      byte_count_next = eff_count + COUNT_W'(1);
      message_id_reg_next = id_new;
      if (eff_count >= BODY_START && eff_count < BODY_START + len_b) begin
        crc_reg_next = crc16_x25_byte(eff_crc, unpack.byte_value);
      end else if (eff_count == BODY_START + len_b) begin
        fcs_low_next = unpack.byte_value;
      end else if (eff_count == BODY_START + len_b + COUNT_W'(1)) begin
        fcs_high_next = unpack.byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weak_threshold <= THRESH_RESET;
      frame_active <= 1'b0;
      byte_count <= '0;
      crc_reg <= CRC_INIT;
      message_id_reg <= 6'd0;
      fcs_low <= 8'd0;
      fcs_high <= 8'd0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        weak_threshold <= cfg.weak_threshold;
      end
      frame_active <= frame_active_next;
      byte_count <= byte_count_next;
      crc_reg <= crc_reg_next;
      message_id_reg <= message_id_reg_next;
      fcs_low <= fcs_low_next;
      fcs_high <= fcs_high_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.kind         = res.kind;
  assign result.byte_value   = res.byte_value;
  assign result.byte_index   = res.byte_index;
  assign result.crc_ok       = res.crc_ok;
  assign result.message_kind = res.message_kind;
  assign result.short_frame  = res.short_frame;

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_FRAME_BYTES))
    else $error("byte count beyond frame limit");

  a_verdict_closes: assert property (@(posedge clk) disable iff (rst)
    verdict |=> !frame_active && res_valid && res.kind == KIND_VERDICT)
    else $error("verdict did not close the frame");

  a_short_not_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.short_frame |-> !res.crc_ok && res.kind == KIND_VERDICT)
    else $error("short frame flagged with good crc");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |=> res_valid && $stable(res))
    else $error("pending result lost");

endmodule

>>> dv/ais_hdlc_frame_receiver_unit_tb.sv
module ais_hdlc_frame_receiver_unit_tb;
  import ahfr_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [AMP_W-1:0] AMP_MAX = '1;

  // Frame decoder prediction plus the queue of results still owed by the block
  class frame_scoreboard;
    logic [AMP_W-1:0] thresh = THRESH_RESET;
    bit active;
    bit level_seen;
    bit last_level;
    int ones_run;
    int bit_pos;
    logic [COUNT_W-1:0] byte_cnt;
    logic [7:0] shift_reg;
    logic [7:0] fcs_lo;
    logic [7:0] fcs_hi;
    logic [15:0] crc;
    logic [5:0] msg_id;
    result_t owed[$];
    int errors;
    int n_bytes;
    int n_verdicts;
    int n_crc_good;
    int n_short;

    function new();
      clear_frame();
    endfunction

    // reflected X.25 polynomial, bit at a time
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
        c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
    endfunction

    function void clear_frame();
      level_seen = 1'b0;
      last_level = 1'b0;
      ones_run = 0;
      bit_pos = 0;
      byte_cnt = '0;
      shift_reg = '0;
      crc = CRC_INIT;
      msg_id = '0;
      fcs_lo = '0;
      fcs_hi = '0;
    endfunction

    function logic [COUNT_W-1:0] body_len();
      return (msg_id == ID_LONG) ? LEN_LONG : LEN_SHORT;
    endfunction

    function void note_symbol(bit start, logic [AMP_W-1:0] amp, bit fm_pos);
      result_t r;
      bit lvl;
      bit rx;
      logic [COUNT_W-1:0] idx;
      lvl = !fm_pos;
      if (start) begin
        active = 1'b1;
        clear_frame();
      end
      if (!active) return;
      r = '0;
      r.kind = KIND_BYTE;
      if (amp < thresh) begin
        active = 1'b0;
        r.kind = KIND_VERDICT;
        r.byte_index = byte_cnt[7:0];
        r.message_kind = msg_id;
        r.short_frame = byte_cnt < BODY_START + body_len() + FCS_BYTES;
        if (!r.short_frame)
          r.crc_ok = (~crc == {fcs_hi, fcs_lo});
        owed.push_back(r);
        return;
      end
      // NRZI: same level as before is a 1
      rx = level_seen && (lvl == last_level);
      last_level = lvl;
      level_seen = 1'b1;
      if (ones_run >= 5) begin
        ones_run = 0;
        if (!rx) return;
      end
      ones_run = rx ? ones_run + 1 : 0;
      if (rx) shift_reg[bit_pos] = 1'b1;
      if (bit_pos < 7) begin
        bit_pos++;
        return;
      end
      bit_pos = 0;
      if (byte_cnt >= MAX_FRAME_BYTES) begin
        shift_reg = '0;
        return;
      end
      idx = byte_cnt;
      byte_cnt++;
      if (idx == BODY_START) msg_id = shift_reg[7:2];
      if (idx >= BODY_START && idx < BODY_START + body_len())
        crc = crc_step(crc, shift_reg);
      else if (idx == BODY_START + body_len())
        fcs_lo = shift_reg;
      else if (idx == BODY_START + body_len() + 1)
        fcs_hi = shift_reg;
      r.byte_value = shift_reg;
      r.byte_index = idx[7:0];
      r.message_kind = msg_id;
      owed.push_back(r);
      shift_reg = '0;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (got.kind == KIND_VERDICT) begin
        n_verdicts++;
        if (got.crc_ok) n_crc_good++;
        if (got.short_frame) n_short++;
      end else begin
        n_bytes++;
      end
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind=%0d value=%02h index=%0d",
                 $time, got.kind, got.byte_value, got.byte_index);
        errors++;
        return;
      end
      want = owed.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("byte_value", want.byte_value, got.byte_value);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("crc_ok", want.crc_ok, got.crc_ok);
      check_field("message_kind", want.message_kind, got.message_kind);
      check_field("short_frame", want.short_frame, got.short_frame);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ahfr_symbol_if symbol_ch ();
  ahfr_result_if result_ch ();
  ahfr_cfg_if cfg_ch ();

  ais_hdlc_frame_receiver_unit u_top (
    .clk(clk),
    .rst(rst),
    .symbol(symbol_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  frame_scoreboard board = new();
  logic [AMP_W-1:0] cur_thresh = THRESH_RESET;
  logic [7:0] frame_bytes[$];
  bit line_bits[$];
  int sent_syms;
  int n_cfg;
  bit sym_steady;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_symbol(bit start, logic [AMP_W-1:0] amp, bit fm);
    int gap;
    if ($urandom_range(0, 63) == 0) sym_steady = !sym_steady;
    gap = sym_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      symbol_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    symbol_ch.valid <= 1'b1;
    symbol_ch.start_req <= start;
    symbol_ch.amplitude <= amp;
    symbol_ch.fm_positive <= fm;
    do @(posedge clk); while (!symbol_ch.ready);
    board.note_symbol(start, amp, fm);
    sent_syms++;
  endtask

  task automatic write_threshold(logic [AMP_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.weak_threshold <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.thresh = v;
    cur_thresh = v;
    n_cfg++;
  endtask

  // wait for every owed result, then let symbols that give none settle
  task automatic drain();
    symbol_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [AMP_W-1:0] strong_amp();
    if ($urandom_range(0, 15) == 0) return cur_thresh;
    return AMP_W'($urandom_range(AMP_MAX, cur_thresh));
  endfunction

  function automatic logic [AMP_W-1:0] weak_amp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return cur_thresh - 1'b1;
      default: return AMP_W'($urandom_range(cur_thresh - 1'b1, 0));
    endcase
  endfunction

  task automatic build_frame(bit long_id, bit good_fcs, int extra);
    logic [15:0] c;
    logic [5:0] id;
    int len;
    int k;
    frame_bytes.delete();
    // first symbol of a frame always decodes as 0
    frame_bytes.push_back(8'($urandom) & 8'hFE);
    repeat (3) frame_bytes.push_back(8'($urandom));
    if (long_id) id = ID_LONG;
    else if ($urandom_range(0, 3) == 0) id = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    else id = 6'($urandom);
    if (!long_id && id == ID_LONG) id = 6'd1;
    frame_bytes.push_back({id, 2'($urandom)});
    len = long_id ? int'(LEN_LONG) : int'(LEN_SHORT);
    repeat (len - 1) frame_bytes.push_back(8'($urandom));
    c = CRC_INIT;
    for (int i = int'(BODY_START); i < int'(BODY_START) + len; i++)
      c = frame_scoreboard::crc_step(c, frame_bytes[i]);
    c = ~c;
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    if (!good_fcs) begin
      k = $urandom_range(int'(BODY_START), frame_bytes.size() - 1);
      frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    repeat (extra) frame_bytes.push_back(8'($urandom));
  endtask

  // cut_bits < 0 sends the whole frame; end_weak closes it with a weak symbol unless the threshold is 0
  task automatic send_frame(int cut_bits, bit stuff, bit end_weak);
    int run;
    bit fm;
    line_bits.delete();
    run = 0;
    foreach (frame_bytes[i])
      for (int j = 0; j < 8; j++) begin
        line_bits.push_back(frame_bytes[i][j]);
        run = frame_bytes[i][j] ? run + 1 : 0;
        if (stuff && run == 5) begin
          line_bits.push_back(1'b0);
          run = 0;
        end
      end
    if (cut_bits >= 0)
      while (line_bits.size() > cut_bits) void'(line_bits.pop_back());
    fm = $urandom_range(0, 1);
    foreach (line_bits[i]) begin
      if (i > 0 && !line_bits[i]) fm = !fm;
      send_symbol(i == 0, strong_amp(), fm);
    end
    if (end_weak && cur_thresh != 0) send_symbol(1'b0, weak_amp(), $urandom_range(0, 1));
  endtask

  task automatic send_noise(int n);
    repeat (n) send_symbol($urandom_range(0, 9) == 0, AMP_W'($urandom), $urandom_range(0, 1));
  endtask

  task automatic run_directed();
    send_symbol(1'b0, '0, 1'b0);
    send_symbol(1'b0, AMP_MAX, 1'b1);
    // weak start symbol: short verdict right away
    send_symbol(1'b1, THRESH_RESET - 1'b1, 1'b0);
    send_symbol(1'b1, AMP_MAX, 1'b1);
    // steady line level: ones run past five, sixth one is kept
    repeat (8) send_symbol(1'b0, THRESH_RESET, 1'b1);
    // restart mid-frame, then seven level changes make a zero byte
    send_symbol(1'b1, AMP_MAX, 1'b0);
    for (int i = 0; i < 7; i++) send_symbol(1'b0, AMP_MAX - AMP_W'(i), !i[0]);
    send_symbol(1'b0, '0, 1'b1);
  endtask

  task automatic run_phase(logic [AMP_W-1:0] thr, int budget);
    int stop;
    int pick;
    drain();
    write_threshold(thr);
    stop = sent_syms + budget;
    while (sent_syms < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        build_frame($urandom_range(0, 3) == 0, 1'b1,
                    $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        send_frame(-1, 1'b1, 1'b1);
      end else if (pick < 62) begin
        build_frame($urandom_range(0, 3) == 0, 1'b0, 0);
        send_frame(-1, 1'b1, 1'b1);
      end else if (pick < 74) begin
        build_frame($urandom_range(0, 3) == 0, 1'b1, 0);
        send_frame($urandom_range(1, 8 * frame_bytes.size()), 1'b1, 1'b1);
      end else if (pick < 80) begin
        build_frame($urandom_range(0, 1), 1'b1, 0);
        send_frame(-1, 1'b0, 1'b1);
      end else if (pick < 88) begin
        // left open; a later start aborts it without a verdict unless a weak noise symbol closes it first
        build_frame($urandom_range(0, 1), 1'b1, 0);
        send_frame($urandom_range(1, 8 * frame_bytes.size()), 1'b1, 1'b0);
      end else if (pick < 95 || thr == 0) begin
        send_noise($urandom_range(1, 40));
      end else begin
        send_symbol(1'b1, weak_amp(), $urandom_range(0, 1));
      end
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind = kind_t'(result_ch.kind);
      got.byte_value = result_ch.byte_value;
      got.byte_index = result_ch.byte_index;
      got.crc_ok = result_ch.crc_ok;
      got.message_kind = result_ch.message_kind;
      got.short_frame = result_ch.short_frame;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (symbol_ch.valid && symbol_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results owed", $time, QUIET_LIMIT,
               board.owed.size());
      $display("** ais_hdlc_frame_receiver_unit: FAILED **");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    symbol_ch.valid <= 1'b0;
    symbol_ch.start_req <= 1'b0;
    symbol_ch.amplitude <= '0;
    symbol_ch.fm_positive <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.weak_threshold <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(THRESH_RESET, 500);
    run_phase(AMP_MAX, 150);
    run_phase(AMP_W'(1), 150);
    run_phase('0, 150);
    run_phase(AMP_W'($urandom_range(5, 5000)), 250);
    drain();
    repeat (10) @(posedge clk);

    if (board.owed.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.owed.size());
      board.errors += board.owed.size();
    end
    $display("Sent %0d symbols under %0d threshold settings; checked %0d bytes and %0d verdicts",
             sent_syms, n_cfg, board.n_bytes, board.n_verdicts);
    $display("Verdicts: %0d with good CRC, %0d short frames; %0d mismatches",
             board.n_crc_good, board.n_short, board.errors);
    if (board.errors == 0)
      $display("** ais_hdlc_frame_receiver_unit: PASSED **");
    else
      $display("** ais_hdlc_frame_receiver_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/ahfr_pkg.sv
sv/ahfr_if.sv
sv/ahfr_bit_unpack.sv
sv/ais_hdlc_frame_receiver_unit.sv
dv/ais_hdlc_frame_receiver_unit_tb.sv
